[rtl/indexed_ordered_list_core_assert.svh]
// Assertion macros for the indexed ordered list core.
// The clock is clk and the reset is rst in every module that uses them.
`ifndef INDEXED_ORDERED_LIST_CORE_ASSERT_SVH
`define INDEXED_ORDERED_LIST_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define IOL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define IOL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/iol_pkg.sv]
// Package for the indexed ordered list core: sizes, codes, word types and
// the structs passed between the top level, the cell chain and the cells.
`default_nettype none

package iol_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int WORD_W = 32;
  localparam int FUNC_W = 3;
  localparam int POS_W  = 7;
  localparam int FIDX_W = 6;
  localparam int LEN_W  = 7;
  localparam int STAT_W = 2;

  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    pos_t              position;
    word_t             value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FIDX_W-1:0] found_index;
    word_t             read_value;
    len_t              list_length;
  } rsp_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  // Broadcast to every cell for an insert or remove.
  typedef struct packed {
    cell_op_t op;
    pos_t     position;
    word_t    word;
  } shift_ctl_t;

  // Held steady while a scan word travels down the chain.
  typedef struct packed {
    logic  is_read;
    pos_t  position;
    word_t key;
    len_t  count;
  } scan_ctl_t;

  // The scan word handed from cell to cell.
  typedef struct packed {
    logic  valid;
    logic  hit;
    idx_t  index;
    word_t data;
  } scan_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_SCAN
  } state_t;

endpackage

`default_nettype wire

[rtl/indexed_ordered_list_core.sv]
// Top level of the indexed ordered list core: request decode, list length,
// scan sequencer and response register. Depends on iol_pkg and iol_chain.
//
//   Channel  Signals                        Word
//   request  req_valid, req_ready, req      func, position, value
//   response rsp_valid, rsp_ready, rsp      status, found_index, read_value,
//                                           list_length
//
// Insert, remove, clear and unused codes finish at the accepting edge: the
// response word is loaded into the output register at that edge. Search
// and read send a scan word down the 64-cell chain, one cell per cycle,
// and the chain's tail word is registered as the response. One request is
// in flight at a time. A request is taken only while the output register
// is empty or being drained. Reset empties the list and the output
// register; the stored words themselves are not cleared.
`default_nettype none
`include "indexed_ordered_list_core_assert.svh"

module indexed_ordered_list_core (
  input  wire           clk,
  input  wire           rst,
  input  wire           req_valid,
  output logic          req_ready,
  input  iol_pkg::req_t req,
  output logic          rsp_valid,
  input  wire           rsp_ready,
  output iol_pkg::rsp_t rsp
);
  import iol_pkg::*;

  state_t     state;
  state_t     state_next;
  len_t       count;
  len_t       count_next;
  scan_ctl_t  scan_ctl;
  shift_ctl_t shift;
  scan_t      tail;
  rsp_t       imm_rsp;
  rsp_t       scan_rsp;
  logic       accept;
  logic       launch;
  logic       is_scan;
  logic       insert_ok;
  logic       remove_ok;

  assign accept = req_valid && req_ready;

  // Length checks for the shifting operations. The range test on insert
  // comes before the full test.
  assign insert_ok = (req.position <= count) && (count < LEN_W'(DEPTH));
  assign remove_ok = req.position < count;
  assign is_scan   = (req.func == FN_SEARCH) || (req.func == FN_READ);

  // Decode of the immediate operations into the cell broadcast, the new
  // length and the immediate response word.
  always_comb begin
    shift.op       = CELL_HOLD;
    shift.position = req.position;
    shift.word     = req.value;
    count_next     = count;
    imm_rsp        = '0;
    imm_rsp.status = ST_DONE;
    unique case (req.func)
      FN_INSERT: begin
        if (req.position > count) begin
          imm_rsp.status = ST_RANGE;
        end else if (!insert_ok) begin
          imm_rsp.status = ST_FULL;
        end else begin
          shift.op   = accept ? CELL_INSERT : CELL_HOLD;
          count_next = count + 1'b1;
        end
      end
      FN_REMOVE: begin
        if (!remove_ok) begin
          imm_rsp.status = ST_RANGE;
        end else begin
          shift.op   = accept ? CELL_REMOVE : CELL_HOLD;
          count_next = count - 1'b1;
        end
      end
      FN_CLEAR: count_next = '0;
      default: count_next = count;
    endcase
    imm_rsp.list_length = count_next;
  end

  // The chain's tail word becomes the search or read response.
  always_comb begin
    scan_rsp             = '0;
    scan_rsp.list_length = scan_ctl.count;
    if (scan_ctl.is_read) begin
      scan_rsp.status = tail.hit ? ST_DONE : ST_RANGE;
      if (tail.hit) begin
        scan_rsp.read_value = tail.data;
      end
    end else begin
      scan_rsp.status = tail.hit ? ST_DONE : ST_MISS;
      if (tail.hit) begin
        scan_rsp.found_index = FIDX_W'(tail.index);
      end
    end
  end

  // Scan sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && is_scan) begin
          state_next = S_LAUNCH;
        end
      end
      S_LAUNCH: state_next = S_SCAN;
      S_SCAN: begin
        if (tail.valid) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Scan sequencer: outputs.
  always_comb begin
    req_ready = 1'b0;
    launch    = 1'b0;
    unique case (state)
      S_IDLE:   req_ready = !rsp_valid || rsp_ready;
      S_LAUNCH: launch    = 1'b1;
      S_SCAN:   launch    = 1'b0;
      default:  req_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // Search and read parameters stay put for the whole scan.
  always_ff @(posedge clk) begin
    if (accept && is_scan) begin
      scan_ctl.is_read  <= (req.func == FN_READ);
      scan_ctl.position <= req.position;
      scan_ctl.key      <= req.value;
      scan_ctl.count    <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((accept && !is_scan) || tail.valid) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_scan) begin
      rsp <= imm_rsp;
    end else if (tail.valid) begin
      rsp <= scan_rsp;
    end
  end

  iol_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .shift    (shift),
    .scan_ctl (scan_ctl),
    .launch   (launch),
    .tail     (tail)
  );

  `IOL_ASSERT_SAME(a_len_bound, 1'b1, count <= LEN_W'(DEPTH), "list length above depth")
  `IOL_ASSERT_NEXT(a_insert_grows, accept && req.func == FN_INSERT && insert_ok,
    count == $past(count) + 1'b1, "insert did not grow the list")
  `IOL_ASSERT_SAME(a_tail_in_scan, tail.valid, state == S_SCAN, "scan word outside a scan")
  `IOL_ASSERT_SAME(a_no_overrun, rsp_valid && !rsp_ready, !req_ready,
    "request taken while response is blocked")

endmodule

`default_nettype wire

[rtl/iol_cell.sv]
// One list cell: holds one stored word and one stage of the scan chain.
// Depends on iol_pkg.
`default_nettype none

module iol_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  iol_pkg::idx_t       index,
  input  iol_pkg::shift_ctl_t shift,
  input  iol_pkg::scan_ctl_t  scan_ctl,
  input  iol_pkg::word_t      left_word,
  input  iol_pkg::word_t      right_word,
  output iol_pkg::word_t      word,
  input  iol_pkg::scan_t      scan_in,
  output iol_pkg::scan_t      scan_out
);
  import iol_pkg::*;

  word_t word_next;
  scan_t scan_next;
  pos_t  my_pos;
  logic  is_match;

  assign my_pos = POS_W'(index);

  // Insert moves every entry at or above the position up by one; remove
  // moves every entry above the position down by one.
  always_comb begin
    word_next = word;
    unique case (shift.op)
      CELL_INSERT: begin
        if (my_pos > shift.position) begin
          word_next = left_word;
        end else if (my_pos == shift.position) begin
          word_next = shift.word;
        end
      end
      CELL_REMOVE: begin
        if (my_pos >= shift.position) begin
          word_next = right_word;
        end
      end
      default: word_next = word;
    endcase
  end

  always_comb begin
    is_match = (my_pos < scan_ctl.count) &&
               (scan_ctl.is_read ? (my_pos == scan_ctl.position)
                                 : (word == scan_ctl.key));
    scan_next = scan_in;
    if (scan_in.valid && !scan_in.hit && is_match) begin
      scan_next.hit   = 1'b1;
      scan_next.index = index;
      scan_next.data  = word;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // Only the valid bit of the scan stage is reset; the rest is qualified by it.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out.valid <= scan_next.valid;
    end
    scan_out.hit   <= scan_next.hit;
    scan_out.index <= scan_next.index;
    scan_out.data  <= scan_next.data;
  end

endmodule

`default_nettype wire

[rtl/iol_chain.sv]
// Row of list cells: wires each cell's word to its neighbors and threads
// the scan word from the head cell to the tail. Depends on iol_pkg, iol_cell.
`default_nettype none

module iol_chain (
  input  wire                 clk,
  input  wire                 rst,
  input  iol_pkg::shift_ctl_t shift,
  input  iol_pkg::scan_ctl_t  scan_ctl,
  input  wire                 launch,
  output iol_pkg::scan_t      tail
);
  import iol_pkg::*;

  word_t words [DEPTH];
  scan_t links [DEPTH+1];

  always_comb begin
    links[0]       = '0;
    links[0].valid = launch;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t left_w;
    word_t right_w;

    if (g == 0) begin : g_head
      assign left_w = shift.word;
    end else begin : g_left
      assign left_w = words[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_w = words[g];
    end else begin : g_right
      assign right_w = words[g+1];
    end

    iol_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .index      (IDX_W'(g)),
      .shift      (shift),
      .scan_ctl   (scan_ctl),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[g]),
      .scan_in    (links[g]),
      .scan_out   (links[g+1])
    );
  end

  assign tail = links[DEPTH];

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for indexed_ordered_list_core: a directed list walk, then
// random grow, shrink and mixed phases, checked against an in-bench list predictor.
// Depends on iol_pkg and the core RTL only.
`default_nettype none

module tb_top;
  import iol_pkg::*;

  localparam int PERIOD       = 12;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 80;
  localparam int RANDOM_WORDS = 1300;
  localparam int MAX_REPORTS  = 10;
  localparam int POOL_SIZE    = 16;

  // Codes 5 to 7 are not assigned to any operation.
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_MID = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} phase_t;

  typedef struct {
    req_t word;
    bit   hold_for_drain;
  } pending_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  indexed_ordered_list_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  pending_t pending_words[$];
  rsp_t     predicted_rsps[$];

  // Predictor state: the list contents and its length.
  word_t list_words [DEPTH];
  int    list_len = 0;

  // Rough length estimate used only to aim positions while building stimulus.
  int    plan_len = 0;
  word_t value_pool [POOL_SIZE];

  int       words_queued = 0;
  int       words_sent   = 0;
  int       mismatches   = 0;
  int       idle_cycles  = 0;
  logic     req_fired    = 1'b0;
  int       send_gap     = 0;
  int       send_calm    = 0;
  int       recv_stall   = 0;
  int       recv_calm    = 0;
  pending_t next_word;

  initial begin
    clk = 1'b0;
    forever #(PERIOD / 2) clk = ~clk;
  end

  // Applies one request to the predicted list and returns the response word.
  function automatic rsp_t list_operation_result(req_t r);
    rsp_t res;
    int   p;
    res    = '0;
    res.status = ST_DONE;
    p      = int'(r.position);
    case (r.func)
      FN_INSERT: begin
        if (p > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int k = list_len; k > p; k--) list_words[k] = list_words[k - 1];
          list_words[p] = r.value;
          list_len++;
        end
      end
      FN_REMOVE: begin
        if (p >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int k = p; k + 1 < list_len; k++) list_words[k] = list_words[k + 1];
          list_len--;
        end
      end
      FN_SEARCH: begin
        res.status = ST_MISS;
        for (int k = 0; k < list_len; k++) begin
          if (res.status == ST_MISS && list_words[k] == r.value) begin
            res.status      = ST_DONE;
            res.found_index = FIDX_W'(k);
          end
        end
      end
      FN_READ: begin
        if (p >= list_len) res.status = ST_RANGE;
        else res.read_value = list_words[p];
      end
      FN_CLEAR: list_len = 0;
      default: ;
    endcase
    res.list_length = len_t'(list_len);
    return res;
  endfunction

  task automatic queue_word(logic [FUNC_W-1:0] f, pos_t p, word_t v, bit hold);
    pending_t w;
    w.word.func      = f;
    w.word.position  = p;
    w.word.value     = v;
    w.hold_for_drain = hold;
    pending_words.push_back(w);
    words_queued++;
    case (f)
      FN_INSERT: if (int'(p) <= plan_len && plan_len < DEPTH) plan_len++;
      FN_REMOVE: if (int'(p) < plan_len) plan_len--;
      FN_CLEAR:  plan_len = 0;
      default: ;
    endcase
  endtask

  // top is the highest legal position, or -1 when there is none.
  function automatic pos_t pick_position(int top);
    int roll;
    roll = $urandom_range(0, 99);
    if (top < 0) return pos_t'($urandom_range(0, DEPTH));
    if (roll < 10) return '0;
    if (roll < 25) return pos_t'(top);
    if (roll < 90 || top >= DEPTH) return pos_t'($urandom_range(0, top));
    return pos_t'($urandom_range(top + 1, DEPTH));
  endfunction

  // Half the values repeat from a small pool so that searches hit.
  function automatic word_t pick_value();
    if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return word_t'($urandom);
  endfunction

  // Mostly short idles, a few long ones, and now and then a calm stretch.
  function automatic int idle_len(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 199);
    if (roll == 0) begin
      calm = $urandom_range(50, 150);
      return 0;
    end
    if (roll < 110) return 0;
    if (roll < 170) return $urandom_range(1, 3);
    if (roll < 194) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic check_response(rsp_t got);
    rsp_t want;
    if (predicted_rsps.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected response word: status %0d found %0d read %0d len %0d",
                 got.status, got.found_index, got.read_value, got.list_length);
    end else begin
      want = predicted_rsps.pop_front();
      if (got.status !== want.status || got.found_index !== want.found_index ||
          got.read_value !== want.read_value || got.list_length !== want.list_length) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("response mismatch: expected status %0d found %0d read %0d len %0d, got status %0d found %0d read %0d len %0d",
                   want.status, want.found_index, want.read_value, want.list_length,
                   got.status, got.found_index, got.read_value, got.list_length);
      end
    end
  endtask

  // Request driver: holds each word until taken, then idles for its gap.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fired) begin
      if (send_gap > 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (pending_words.size() != 0 &&
                   !(pending_words[0].hold_for_drain && predicted_rsps.size() != 0)) begin
        next_word = pending_words.pop_front();
        req       <= next_word.word;
        req_valid <= 1'b1;
        send_gap  = idle_len(send_calm);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response side back-pressure.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) recv_stall = idle_len(recv_calm);
    end
  end

  // Monitor: check responses first, then predict for the request taken at this edge.
  always @(posedge clk) begin
    if (rst) begin
      req_fired   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      req_fired <= req_valid && req_ready;
      if (rsp_valid && rsp_ready) check_response(rsp);
      if (req_valid && req_ready) begin
        predicted_rsps.push_back(list_operation_result(req));
        words_sent++;
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int                n;
    int                roll;
    int                phase_left;
    phase_t            phase;
    logic [FUNC_W-1:0] f;
    pos_t              p;
    bit                hold;

    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7FFF_FFFF;
    value_pool[2] = '0;
    value_pool[3] = -1;
    for (int k = 4; k < POOL_SIZE; k++) value_pool[k] = word_t'($urandom);

    // Directed walk over the special cases.
    queue_word(FN_READ,   7'd0, '0, 1'b0);              // read on empty list
    queue_word(FN_REMOVE, 7'd0, '0, 1'b0);              // remove on empty list
    queue_word(FN_SEARCH, 7'd0, '0, 1'b0);              // search miss on empty list
    queue_word(FN_INSERT, 7'd1, 32'sd5, 1'b0);          // insert past the end
    queue_word(FN_INSERT, 7'd0, 32'sh7FFF_FFFF, 1'b0);
    queue_word(FN_INSERT, 7'd1, 32'sh8000_0000, 1'b0);  // append
    queue_word(FN_INSERT, 7'd0, -1, 1'b0);              // insert at the front
    queue_word(FN_INSERT, 7'd1, '0, 1'b0);              // insert in the middle
    queue_word(FN_INSERT, 7'd4, -1, 1'b0);              // duplicate at the end
    queue_word(FN_SEARCH, 7'd0, -1, 1'b0);              // first of two matches
    queue_word(FN_SEARCH, 7'd0, 32'sh8000_0000, 1'b0);
    queue_word(FN_SEARCH, 7'd0, 32'sd12345, 1'b0);      // search miss
    queue_word(FN_READ,   7'd3, '0, 1'b0);
    queue_word(FN_READ,   7'd5, '0, 1'b0);              // read just past the last entry
    queue_word(FN_READ,   7'd64, '0, 1'b0);
    queue_word(FN_REMOVE, 7'd5, '0, 1'b0);              // remove just past the last entry
    queue_word(FN_INSERT, 7'd64, 32'sd9, 1'b0);
    queue_word(FN_REMOVE, 7'd0, '0, 1'b0);
    queue_word(FN_REMOVE, 7'd3, '0, 1'b0);              // remove the last entry
    queue_word(FN_SPARE_LO,  7'd64, word_t'($urandom), 1'b0);
    queue_word(FN_SPARE_MID, 7'd1, word_t'($urandom), 1'b0);
    queue_word(FN_SPARE_HI,  7'd0, word_t'($urandom), 1'b0);
    queue_word(FN_CLEAR,  7'd17, '0, 1'b0);
    queue_word(FN_READ,   7'd0, '0, 1'b0);              // old words are gone after clear
    queue_word(FN_SEARCH, 7'd0, '0, 1'b0);

    // Random phases: growth runs fill the store, shrink runs drain it.
    phase_left = 0;
    phase      = PH_GROW;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        phase      = phase_t'($urandom_range(0, 2));
        phase_left = $urandom_range(30, 120);
      end
      phase_left--;
      hold = (n == 0) || ($urandom_range(0, 99) == 0);
      roll = $urandom_range(0, 99);
      case (phase)
        PH_GROW:   f = roll < 70 ? FN_INSERT : roll < 78 ? FN_REMOVE :
                       roll < 88 ? FN_SEARCH : roll < 98 ? FN_READ : FN_SPARE_LO;
        PH_SHRINK: f = roll < 20 ? FN_INSERT : roll < 70 ? FN_REMOVE :
                       roll < 83 ? FN_SEARCH : roll < 97 ? FN_READ : FN_CLEAR;
        default:   f = roll < 30 ? FN_INSERT : roll < 55 ? FN_REMOVE :
                       roll < 75 ? FN_SEARCH : roll < 96 ? FN_READ : FN_CLEAR;
      endcase
      if (f == FN_SPARE_LO) f = 3'($urandom_range(int'(FN_SPARE_LO), int'(FN_SPARE_HI)));
      case (f)
        FN_INSERT:          p = pick_position(plan_len);
        FN_REMOVE, FN_READ: p = pick_position(plan_len - 1);
        default:            p = pos_t'($urandom_range(0, DEPTH));
      endcase
      queue_word(f, p, pick_value(), hold);
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (words_sent != words_queued || predicted_rsps.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0 && predicted_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
